// ===== design/bpa_pkg.sv =====
// Buddy page allocator: shared constants, codes, payload and queue types.
// No dependencies; imported by every module of the block but bpa_ram.
`default_nettype none
package bpa_pkg;
  localparam int PAGES     = 1024;
  localparam int MAX_ORDER = 10;
  localparam int PW        = $clog2(PAGES);
  localparam int PCW       = $clog2(PAGES + 1);
  localparam int OW        = $clog2(MAX_ORDER + 1);
  localparam int NL        = MAX_ORDER + 1;
  localparam int TW        = OW + 2;
  localparam int QDEPTH    = 2;

  typedef enum logic [1:0] {CMD_RESERVE, CMD_BUILD, CMD_ALLOC, CMD_FREE} cmd_t;
  typedef enum logic [2:0] {ST_OK, ST_OOM, ST_TOO_LARGE, ST_BAD_FREE, ST_IGNORED} status_t;
  typedef enum logic [1:0] {MK_PLAIN, MK_RSVD, MK_BODY, MK_FREE} mark_t;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RSV, S_BRD, S_BCHK, S_CARVE, S_A1, S_F1, S_F2, S_F3, S_F4,
    S_FEND, S_P0, S_P1, S_P2, S_R0, S_R1, S_DONE
  } eng_state_t;

  typedef struct packed {
    cmd_t        cmd;
    logic [15:0] page_count;
    logic [9:0]  page_index;
    logic [10:0] end_page;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [9:0]  block_page;
    logic [3:0]  block_order;
  } out_item_t;

  typedef struct packed {
    cmd_t           cmd;
    logic [PCW-1:0] idx;
    logic [PCW-1:0] endp;
    logic [OW-1:0]  order;
    logic           too_big;
  } q_item_t;

  typedef struct packed {
    logic clearing;
    logic pop;
  } eng_ctl_t;

  function automatic logic [OW-1:0] carve_order(input logic [PCW-1:0] s,
                                                input logic [PCW-1:0] cnt);
    logic [OW-1:0] o;
    logic          go;
    o  = '0;
    go = 1'b1;
    for (int k = 0; k < MAX_ORDER; k++) begin
      if (go && (((s >> k) & PCW'(1)) == '0) && ((cnt >> (k + 1)) != '0)) begin
        o = OW'(k + 1);
      end else begin
        go = 1'b0;
      end
    end
    return o;
  endfunction
endpackage
`default_nettype wire

// ===== design/bpa_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module bpa_ram #(
  parameter int W = 8,
  parameter int D = 16,
  localparam int AW = $clog2(D)
) (
  input  wire logic          clk,
  input  wire logic          we,
  input  wire logic [AW-1:0] waddr,
  input  wire logic [W-1:0]  wdata,
  input  wire logic [AW-1:0] raddr,
  output logic      [W-1:0]  rdata
);
  logic [W-1:0] mem [D];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== design/bpa_front.sv =====
// Front end: accepts commands, rounds request size, saturates range end,
// and queues classified items for the engine. Depends on bpa_pkg.
`default_nettype none
module bpa_front import bpa_pkg::*; (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire in_item_t in_data,
  input  wire eng_ctl_t ctl,
  output logic          q_valid,
  output q_item_t       q_data
);
  q_item_t    mem_r [QDEPTH];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  q_item_t    cls;
  logic [4:0] ord;
  logic [15:0] cm1;
  logic       push;

  always_comb begin
    cm1 = (in_data.page_count == '0) ? 16'd0 : in_data.page_count - 16'd1;
    ord = '0;
    for (int k = 0; k < 16; k++) begin
      if (cm1[k]) ord = 5'(k + 1);
    end
    cls.cmd     = in_data.cmd;
    cls.idx     = PCW'(in_data.page_index);
    cls.endp    = (32'(in_data.end_page) > PAGES) ? PCW'(PAGES) : PCW'(in_data.end_page);
    cls.too_big = (32'(ord) > MAX_ORDER);
    cls.order   = OW'(ord);
  end

  assign in_stall = (cnt_r == 2'(QDEPTH)) || ctl.clearing;
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt_r != '0);
  assign q_data   = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) mem_r[wp_r] <= cls;
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (ctl.pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + 2'(push) - 2'(ctl.pop);
    end
  end
endmodule
`default_nettype wire

// ===== design/bpa_engine.sv =====
// Back end: sequencer that carries out reserve, build, allocate and free
// over the page table and free-list link RAMs. Depends on bpa_pkg, bpa_ram.
`default_nettype none
module bpa_engine import bpa_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    q_valid,
  input  wire q_item_t q_data,
  output eng_ctl_t     ctl,
  output logic         out_valid,
  input  wire logic    out_stall,
  output out_item_t    out_data
);
  eng_state_t st_r, st_nxt, ret_r, ret_nxt;
  q_item_t    cur_r, cur_nxt;
  out_item_t  res_r, res_nxt, out_r, out_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic [PCW-1:0] i_r, i_nxt, s_r, s_nxt, cnt_r, cnt_nxt;
  logic [PW-1:0]  pg_r, pg_nxt, b_r, b_nxt;
  logic [OW-1:0]  ord_r, ord_nxt, c_r, c_nxt, o_r, o_nxt;
  logic       in_run_r, in_run_nxt, built_r, built_nxt;
  logic [NL-1:0] ne_r, ne_nxt;
  logic [PW-1:0] head_r [NL];
  logic [PW-1:0] head_nxt [NL];

  logic          pt_we;
  logic [PW-1:0] pt_wa, pt_ra;
  logic [TW-1:0] pt_wd, pt_rd;
  logic          nx_we, pv_we;
  logic [PW-1:0] nx_wa, nx_wd, nx_ra, nx_rd, pv_wa, pv_wd, pv_ra, pv_rd;
  mark_t         rd_mark;
  logic [OW-1:0] rd_ord, co, cc, found_c;
  logic          found;
  logic [PCW-1:0] bd, step;
  logic [PW-1:0] hi, lo;

  bpa_ram #(.W(TW), .D(PAGES)) u_pt (.clk, .we(pt_we), .waddr(pt_wa), .wdata(pt_wd),
                                     .raddr(pt_ra), .rdata(pt_rd));
  bpa_ram #(.W(PW), .D(PAGES)) u_nx (.clk, .we(nx_we), .waddr(nx_wa), .wdata(nx_wd),
                                     .raddr(nx_ra), .rdata(nx_rd));
  bpa_ram #(.W(PW), .D(PAGES)) u_pv (.clk, .we(pv_we), .waddr(pv_wa), .wdata(pv_wd),
                                     .raddr(pv_ra), .rdata(pv_rd));

  assign rd_mark   = mark_t'(pt_rd[TW-1:OW]);
  assign rd_ord    = pt_rd[OW-1:0];
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    found   = 1'b0;
    found_c = '0;
    for (int k = 0; k < NL; k++) begin
      if (!found && ne_r[k] && (OW'(k) >= q_data.order)) begin
        found   = 1'b1;
        found_c = OW'(k);
      end
    end
  end

  always_comb begin
    st_nxt = st_r; ret_nxt = ret_r; cur_nxt = cur_r; res_nxt = res_r;
    out_nxt = out_r; out_valid_nxt = out_valid_r;
    i_nxt = i_r; s_nxt = s_r; cnt_nxt = cnt_r; pg_nxt = pg_r; b_nxt = b_r;
    ord_nxt = ord_r; c_nxt = c_r; o_nxt = o_r; in_run_nxt = in_run_r;
    built_nxt = built_r; ne_nxt = ne_r;
    for (int k = 0; k < NL; k++) head_nxt[k] = head_r[k];
    pt_we = 1'b0; pt_wa = i_r[PW-1:0]; pt_wd = '0; pt_ra = i_r[PW-1:0];
    nx_we = 1'b0; nx_wa = pg_r; nx_wd = pg_r; nx_ra = pg_r;
    pv_we = 1'b0; pv_wa = pg_r; pv_wd = pg_r; pv_ra = pg_r;
    ctl.clearing = (st_r == S_CLR);
    ctl.pop = 1'b0;
    co = carve_order(s_r, cnt_r);
    cc = c_r - OW'(1);
    step = PCW'(1) << o_r;
    bd = PCW'(b_r) ^ step;
    hi = (pg_r > b_r) ? pg_r : b_r;
    lo = (pg_r > b_r) ? b_r : pg_r;
    if (out_valid_r && !out_stall) out_valid_nxt = 1'b0;

    case (st_r)
      S_CLR: begin
        pt_we = 1'b1;
        i_nxt = i_r + PCW'(1);
        if (i_r == PCW'(PAGES - 1)) st_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (q_valid) begin
          ctl.pop = 1'b1;
          cur_nxt = q_data;
          res_nxt = '{status: ST_OK, block_page: '0, block_order: '0};
          st_nxt = S_DONE;
          case (q_data.cmd)
            CMD_RESERVE: begin
              if (built_r) res_nxt.status = ST_IGNORED;
              else begin
                i_nxt = q_data.idx;
                st_nxt = S_RSV;
              end
            end
            CMD_BUILD: begin
              if (built_r) res_nxt.status = ST_IGNORED;
              else begin
                i_nxt = '0;
                in_run_nxt = 1'b0;
                st_nxt = S_BRD;
              end
            end
            CMD_ALLOC: begin
              if (!built_r) res_nxt.status = ST_IGNORED;
              else if (q_data.too_big) res_nxt.status = ST_TOO_LARGE;
              else if (!found) res_nxt.status = ST_OOM;
              else begin
                b_nxt = head_r[found_c];
                pg_nxt = head_r[found_c];
                c_nxt = found_c;
                ord_nxt = found_c;
                o_nxt = q_data.order;
                ret_nxt = S_A1;
                st_nxt = S_R0;
              end
            end
            default: begin
              if (!built_r) res_nxt.status = ST_IGNORED;
              else if (32'(q_data.idx) >= PAGES) res_nxt.status = ST_BAD_FREE;
              else begin
                pt_ra = q_data.idx[PW-1:0];
                b_nxt = q_data.idx[PW-1:0];
                st_nxt = S_F1;
              end
            end
          endcase
        end
      end
      S_RSV: begin
        if (i_r < cur_r.endp) begin
          pt_we = 1'b1;
          pt_wd = {MK_RSVD, OW'(0)};
          i_nxt = i_r + PCW'(1);
        end else st_nxt = S_DONE;
      end
      S_BRD: begin
        if (i_r == PCW'(PAGES)) begin
          if (in_run_r) begin
            cnt_nxt = i_r - s_r;
            in_run_nxt = 1'b0;
            st_nxt = S_CARVE;
          end else begin
            built_nxt = 1'b1;
            st_nxt = S_DONE;
          end
        end else st_nxt = S_BCHK;
      end
      S_BCHK: begin
        st_nxt = S_BRD;
        if (rd_mark == MK_RSVD) begin
          if (in_run_r) begin
            cnt_nxt = i_r - s_r;
            in_run_nxt = 1'b0;
            st_nxt = S_CARVE;
          end else i_nxt = i_r + PCW'(1);
        end else begin
          if (!in_run_r) begin
            s_nxt = i_r;
            in_run_nxt = 1'b1;
          end
          pt_we = 1'b1;
          pt_wd = {MK_BODY, OW'(0)};
          i_nxt = i_r + PCW'(1);
        end
      end
      S_CARVE: begin
        if (cnt_r == '0) st_nxt = S_BRD;
        else begin
          pt_we = 1'b1;
          pt_wa = s_r[PW-1:0];
          pt_wd = {MK_FREE, co};
          pg_nxt = s_r[PW-1:0];
          ord_nxt = co;
          s_nxt = s_r + (PCW'(1) << co);
          cnt_nxt = cnt_r - (PCW'(1) << co);
          ret_nxt = S_CARVE;
          st_nxt = S_P0;
        end
      end
      S_A1: begin
        if (c_r > o_r) begin
          pg_nxt = b_r + (PW'(1) << cc);
          pt_we = 1'b1;
          pt_wa = b_r + (PW'(1) << cc);
          pt_wd = {MK_FREE, cc};
          c_nxt = cc;
          ord_nxt = cc;
          ret_nxt = S_A1;
          st_nxt = S_P0;
        end else begin
          pt_we = 1'b1;
          pt_wa = b_r;
          pt_wd = {MK_PLAIN, o_r};
          res_nxt.block_page = 10'(b_r);
          res_nxt.block_order = 4'(o_r);
          st_nxt = S_DONE;
        end
      end
      S_F1: begin
        if (rd_mark != MK_PLAIN) begin
          res_nxt.status = ST_BAD_FREE;
          st_nxt = S_DONE;
        end else begin
          o_nxt = rd_ord;
          st_nxt = S_F2;
        end
      end
      S_F2: begin
        if ((32'(o_r) >= MAX_ORDER) || (32'(bd) >= PAGES)) st_nxt = S_FEND;
        else begin
          pt_ra = bd[PW-1:0];
          pg_nxt = bd[PW-1:0];
          st_nxt = S_F3;
        end
      end
      S_F3: begin
        if ((rd_mark != MK_FREE) || (rd_ord != o_r)) st_nxt = S_FEND;
        else begin
          ord_nxt = o_r;
          ret_nxt = S_F4;
          st_nxt = S_R0;
        end
      end
      S_F4: begin
        pt_we = 1'b1;
        pt_wa = hi;
        pt_wd = {MK_BODY, OW'(0)};
        b_nxt = lo;
        o_nxt = o_r + OW'(1);
        st_nxt = S_F2;
      end
      S_FEND: begin
        pt_we = 1'b1;
        pt_wa = b_r;
        pt_wd = {MK_FREE, o_r};
        pg_nxt = b_r;
        ord_nxt = o_r;
        ret_nxt = S_DONE;
        st_nxt = S_P0;
      end
      S_P0: begin
        if (!ne_r[ord_r]) begin
          ne_nxt[ord_r] = 1'b1;
          head_nxt[ord_r] = pg_r;
          nx_we = 1'b1;
          pv_we = 1'b1;
          st_nxt = ret_r;
        end else begin
          pv_ra = head_r[ord_r];
          st_nxt = S_P1;
        end
      end
      S_P1: begin
        nx_we = 1'b1;
        nx_wa = pv_rd;
        nx_wd = pg_r;
        pv_we = 1'b1;
        pv_wa = pg_r;
        pv_wd = pv_rd;
        st_nxt = S_P2;
      end
      S_P2: begin
        nx_we = 1'b1;
        nx_wa = pg_r;
        nx_wd = head_r[ord_r];
        pv_we = 1'b1;
        pv_wa = head_r[ord_r];
        pv_wd = pg_r;
        st_nxt = ret_r;
      end
      S_R0: begin
        st_nxt = S_R1;
      end
      S_R1: begin
        st_nxt = ret_r;
        if (nx_rd == pg_r) ne_nxt[ord_r] = 1'b0;
        else begin
          nx_we = 1'b1;
          nx_wa = pv_rd;
          nx_wd = nx_rd;
          pv_we = 1'b1;
          pv_wa = nx_rd;
          pv_wd = pv_rd;
          if (head_r[ord_r] == pg_r) head_nxt[ord_r] = nx_rd;
        end
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_nxt = res_r;
          st_nxt = S_IDLE;
        end
      end
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt; res_r <= res_nxt; out_r <= out_nxt; ret_r <= ret_nxt;
    s_r <= s_nxt; cnt_r <= cnt_nxt; pg_r <= pg_nxt; b_r <= b_nxt;
    ord_r <= ord_nxt; c_r <= c_nxt; o_r <= o_nxt;
    for (int k = 0; k < NL; k++) head_r[k] <= head_nxt[k];
    if (!rst_n) begin
      st_r <= S_CLR;
      i_r <= '0;
      in_run_r <= 1'b0;
      built_r <= 1'b0;
      ne_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      i_r <= i_nxt;
      in_run_r <= in_run_nxt;
      built_r <= built_nxt;
      ne_r <= ne_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.pop |-> (st_r == S_IDLE)) else $error("pop outside idle");
  a_built_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    built_r |=> built_r) else $error("built flag dropped");
  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_DONE) && !out_valid_r |=> out_valid_r && (st_r == S_IDLE))
    else $error("result not loaded");
  a_no_pop_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == S_CLR) |-> !ctl.pop && !out_valid_r) else $error("activity while clearing");
endmodule
`default_nettype wire

// ===== design/buddy_page_allocator.sv =====
// Buddy page allocator: top level joining the command front end and the
// allocation engine. Depends on bpa_pkg, bpa_front, bpa_engine.
//
// Channels: in_valid/in_stall/in_data carries commands (reserve, build,
// allocate, free); out_valid/out_stall/out_data returns one result beat per
// command. A beat moves at a clock edge with valid high and stall low.
// After reset the engine clears the page table, one page per cycle, over all
// PAGES (1024) pages with in_stall held high.
// Commands queue in a two-entry buffer; the engine runs one at a time.
// Run time per command is set by the one-read, one-write page table and link RAMs:
//   reserve: grows with the range length
//   build: grows with the page count and the number of carved blocks
//   allocate: grows with the number of split levels
//   free: grows with the number of merge levels; a rejected free is shorter
// A finished result waits in the output register; while out_stall is high
// the engine holds its next result and the front keeps taking commands
// until its buffer fills.
`default_nettype none
module buddy_page_allocator import bpa_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire in_item_t  in_data,
  output logic           out_valid,
  input  wire logic      out_stall,
  output out_item_t      out_data
);
  eng_ctl_t ctl;
  logic     q_valid;
  q_item_t  q_data;

  bpa_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data, .ctl, .q_valid, .q_data
  );

  bpa_engine u_engine (
    .clk, .rst_n, .q_valid, .q_data, .ctl, .out_valid, .out_stall, .out_data
  );
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Testbench for buddy_page_allocator: directed and random command beats
// checked against an in-bench buddy allocator prediction. Depends on bpa_pkg.
`default_nettype none
module tb_top;
  import bpa_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  buddy_page_allocator u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always #10 clk = ~clk;

  // predicted allocator state
  logic [3:0]  pg_ord [PAGES];
  mark_t       pg_mark [PAGES];
  int          nxt [PAGES];
  int          prv [PAGES];
  int          head [NL];
  bit          is_built;

  out_item_t   want_q[$];
  int          errors = 0;
  bit          noidle = 1'b0;
  int          quiet = 0;
  int          held [$];   // allocated block heads

  // model free lists: per-order circular lists, tail append and unlink
  function automatic void push_tail(int pg, int o);
    int h, t;
    h = head[o];
    if (h >= PAGES) begin
      head[o] = pg; nxt[pg] = pg; prv[pg] = pg;
    end else begin
      t = prv[h]; nxt[t] = pg; prv[pg] = t; nxt[pg] = h; prv[h] = pg;
    end
  endfunction

  function automatic void unlink_page(int pg, int o);
    int n, p;
    n = nxt[pg]; p = prv[pg];
    if (n == pg) begin
      head[o] = PAGES;
    end else begin
      nxt[p] = n; prv[n] = p;
      if (head[o] == pg) head[o] = n;
    end
  endfunction

  function automatic out_item_t alloc_predict(in_item_t it);
    out_item_t r;
    int cnt, o, c, b, i, s, n, h, p, bd, lo;
    r = '0;
    r.status = ST_OK;
    case (it.cmd)
      CMD_RESERVE: begin
        if (is_built) r.status = ST_IGNORED;
        else begin
          n = (it.end_page > PAGES) ? PAGES : it.end_page;
          for (i = it.page_index; i < n; i++) begin
            pg_mark[i] = MK_RSVD; pg_ord[i] = 4'(0);
          end
        end
      end
      CMD_BUILD: begin
        if (is_built) r.status = ST_IGNORED;
        else begin
          i = 0;
          while (i < PAGES) begin
            if (pg_mark[i] == MK_RSVD) begin
              i++;
            end else begin
              s = i;
              while (i < PAGES && pg_mark[i] != MK_RSVD) begin
                pg_mark[i] = MK_BODY; pg_ord[i] = 4'(0); i++;
              end
              n = i - s;
              while (n > 0) begin
                o = 0;
                while (o < MAX_ORDER && ((s >> o) & 1) == 0 && (2 << o) <= n) o++;
                pg_mark[s] = MK_FREE; pg_ord[s] = 4'(o);
                push_tail(s, o);
                s += 1 << o; n -= 1 << o;
              end
            end
          end
          is_built = 1'b1;
        end
      end
      CMD_ALLOC: begin
        if (!is_built) r.status = ST_IGNORED;
        else begin
          cnt = (it.page_count == 0) ? 1 : it.page_count;
          o = 0;
          while ((1 << o) < cnt) o++;
          if (o > MAX_ORDER) r.status = ST_TOO_LARGE;
          else begin
            c = o;
            while (c <= MAX_ORDER && head[c] >= PAGES) c++;
            if (c > MAX_ORDER) r.status = ST_OOM;
            else begin
              b = head[c];
              unlink_page(b, c);
              while (c > o) begin
                c--;
                h = b + (1 << c);
                pg_mark[h] = MK_FREE; pg_ord[h] = 4'(c);
                push_tail(h, c);
              end
              pg_mark[b] = MK_PLAIN; pg_ord[b] = 4'(o);
              r.block_page = 10'(b); r.block_order = 4'(o);
            end
          end
        end
      end
      default: begin
        if (!is_built) r.status = ST_IGNORED;
        else if (pg_mark[it.page_index] != MK_PLAIN) r.status = ST_BAD_FREE;
        else begin
          p = it.page_index; o = pg_ord[p];
          while (o < MAX_ORDER) begin
            bd = p ^ (1 << o);
            if (bd >= PAGES || pg_mark[bd] != MK_FREE || pg_ord[bd] != o) break;
            unlink_page(bd, o);
            lo = (bd < p) ? bd : p;
            pg_mark[bd < p ? p : bd] = MK_BODY;
            pg_ord[bd < p ? p : bd] = 4'(0);
            p = lo; o++;
          end
          pg_mark[p] = MK_FREE; pg_ord[p] = 4'(o);
          push_tail(p, o);
        end
      end
    endcase
    return r;
  endfunction

  task automatic send_cmd(cmd_t c, int cnt, int idx, int endp);
    in_item_t it;
    out_item_t r;
    it.cmd = c; it.page_count = 16'(cnt); it.page_index = 10'(idx);
    it.end_page = 11'(endp);
    while (!noidle && $urandom_range(99) < 36) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = alloc_predict(it);
    want_q.push_back(r);
    if (c == CMD_ALLOC && r.status == ST_OK) held.push_back(r.block_page);
    if (c == CMD_FREE && r.status == ST_OK)
      foreach (held[k]) if (held[k] == idx) begin held.delete(k); break; end
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (want_q.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    out_stall <= !noidle && ($urandom_range(99) < 36);
  end

  always @(posedge clk) begin
    out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        $error("result beat with nothing expected");
        errors++;
      end else begin
        w = want_q.pop_front();
        if (out_data.status !== w.status) begin
          $error("status: expected %0d actual %0d", w.status, out_data.status); errors++;
        end
        if (out_data.block_page !== w.block_page) begin
          $error("block_page: expected %0d actual %0d", w.block_page,
                 out_data.block_page); errors++;
        end
        if (out_data.block_order !== w.block_order) begin
          $error("block_order: expected %0d actual %0d", w.block_order,
                 out_data.block_order); errors++;
        end
      end
    end
  end

  // watchdog over cycles with no beat moved
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 40000) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic test_before_build();
    send_cmd(CMD_ALLOC, 1, 0, 0);
    send_cmd(CMD_FREE, 0, 0, 0);
    send_cmd(CMD_RESERVE, 0, 3, 7);
    send_cmd(CMD_RESERVE, 0, 100, 90);
    send_cmd(CMD_RESERVE, 0, 1020, 2047);
    send_cmd(CMD_RESERVE, 0, 1023, 1024);
    send_cmd(CMD_RESERVE, 0, 500, 517);
  endtask

  task automatic test_build();
    send_cmd(CMD_BUILD, 0, 0, 0);
    send_cmd(CMD_BUILD, 0, 0, 0);
    send_cmd(CMD_RESERVE, 0, 0, 10);
  endtask

  task automatic test_directed_alloc_free();
    send_cmd(CMD_ALLOC, 0, 0, 0);
    send_cmd(CMD_ALLOC, 65535, 0, 0);
    send_cmd(CMD_ALLOC, 1025, 0, 0);
    send_cmd(CMD_ALLOC, 1024, 0, 0);
    send_cmd(CMD_ALLOC, 512, 0, 0);
    send_cmd(CMD_ALLOC, 3, 0, 0);
    send_cmd(CMD_FREE, 0, 3, 0);
    send_cmd(CMD_FREE, 0, 1023, 0);
    send_cmd(CMD_FREE, 0, 9, 0);
    drain();
    while (held.size() != 0) send_cmd(CMD_FREE, 0, held[0], 0);
    send_cmd(CMD_FREE, 0, 0, 0);
  endtask

  task automatic test_random(int n);
    int v, k;
    for (int i = 0; i < n; i++) begin
      noidle = (i >= n / 3 && i < n / 2);
      v = $urandom_range(99);
      if (v < 45) begin
        k = $urandom_range(9);
        send_cmd(CMD_ALLOC, (k == 0) ? $urandom : $urandom_range(1 << $urandom_range(6)),
                 $urandom, $urandom);
      end else if (v < 85 && held.size() != 0) begin
        send_cmd(CMD_FREE, $urandom, held[$urandom_range(held.size() - 1)], $urandom);
      end else if (v < 95) begin
        send_cmd(CMD_FREE, $urandom, $urandom_range(1023), $urandom);
      end else begin
        send_cmd(cmd_t'($urandom_range(1)), $urandom, $urandom, $urandom);
      end
      if (i == n / 4) drain();
    end
  endtask

  initial begin
    foreach (pg_ord[i]) begin
      pg_ord[i] = 0; pg_mark[i] = MK_PLAIN; nxt[i] = 0; prv[i] = 0;
    end
    foreach (head[i]) head[i] = PAGES;
    is_built = 1'b0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    test_before_build();
    test_build();
    test_directed_alloc_free();
    test_random(1420);
    drain();
    repeat (200) @(posedge clk);
    if (errors == 0 && want_q.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire
